### sv/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg)
`endif
`endif

### sv/irfs_pkg.sv
// ---------------------------------------------------------------------------
// irfs_pkg
// Shared types and constants for the image RVA to file span translator.
// ---------------------------------------------------------------------------
package irfs_pkg;

    localparam int MaxSections = 16;
    localparam int IdxW        = $clog2(MaxSections);
    localparam int CntW        = $clog2(MaxSections + 1);

    // configuration register indexes
    localparam logic [1:0] CFG_ALIGN   = 2'd0;
    localparam logic [1:0] CFG_HEADER  = 2'd1;
    localparam logic [1:0] CFG_FILESZ  = 2'd2;
    localparam logic [1:0] CFG_NSECT   = 2'd3;

    localparam logic REQ_LOAD    = 1'b0;
    localparam logic REQ_RESOLVE = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [3:0]  entry_index;
        logic [63:0] sect_virt_base;
        logic [63:0] sect_virt_length;
        logic [63:0] sect_raw_start;
        logic [63:0] sect_raw_length;
        logic [63:0] query_address;
    } t_req;

    typedef struct packed {
        logic        span_found;
        logic        backing_kind;
        logic [63:0] span_length;
        logic [63:0] file_position;
        logic [4:0]  region_number;
    } t_rsp;

    // divider handshake
    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] rounded;
    } t_div_rsp;

endpackage

### sv/irfs_align_div.sv
// ---------------------------------------------------------------------------
// irfs_align_div
// Bit-serial restoring divider: rounds a 64-bit value down to a multiple of
// a nonzero 32-bit divisor (value - value % divisor). Done is raised once
// the last quotient bit has been shifted in.
// ---------------------------------------------------------------------------
module irfs_align_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  irfs_pkg::t_div_req  i_req,
    output irfs_pkg::t_div_rsp  o_rsp
);
    import irfs_pkg::*;

    logic        r_busy;
    logic [6:0]  r_cnt;
    logic [63:0] r_num;
    logic [63:0] r_orig;
    logic [31:0] r_den;
    logic [32:0] r_rem;
    logic        r_done;

    logic [32:0] w_trial;
    logic [32:0] w_sub;

    assign w_trial = {r_rem[31:0], r_num[63]};
    assign w_sub   = w_trial - {1'b0, r_den};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd0;
            end else if (r_busy) begin
                if (r_cnt == 7'd64) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 7'd1;
                end
            end
        end
    end

    // datapath: one quotient bit per cycle, remainder kept
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num  <= i_req.dividend;
            r_orig <= i_req.dividend;
            r_den  <= i_req.divisor;
            r_rem  <= '0;
        end else if (r_busy && r_cnt != 7'd64) begin
            r_num <= {r_num[62:0], 1'b0};
            if (!w_sub[32]) r_rem <= w_sub;
            else            r_rem <= w_trial;
        end
    end

    assign o_rsp.done    = r_done;
    assign o_rsp.rounded = r_orig - {31'd0, r_rem};

endmodule

### sv/image_rva_to_file_span_core.sv
// ---------------------------------------------------------------------------
// image_rva_to_file_span_core
// Resolves an image RVA to a file span over a loaded section table.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall, payload i_in) carries load and
//   resolve transactions. A load writes one section entry (four 64-bit
//   fields) to the table memory and gives no result. A resolve gives one
//   result transaction on o_out_valid / i_out_stall, payload o_out.
//   Configuration writes through i_cfg_we / i_cfg_index / i_cfg_data while
//   idle.
// Timing:
//   A resolve walks the table memory one entry per cycle, once for virtual
//   extents and once more for raw extents on a miss, then runs the
//   alignment divider on a section hit; the header path resolves in S_FETCH
//   without a scan. The next input is not taken until the resolve is done.
// Reset: control and configuration registers return to reset values; table contents are undefined
//   until loaded.
// Stall: a finished result waits in the output register; the next input is
//   taken while it waits, and a further result waits in a holding slot until it leaves.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module image_rva_to_file_span_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  irfs_pkg::t_req      i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output irfs_pkg::t_rsp      o_out,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [63:0]         i_cfg_data
);
    import irfs_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCANV = 7'b0000010,
        S_SCANR = 7'b0000100,
        S_FETCH = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_CALC  = 7'b0100000,
        S_EMIT  = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    // configuration registers
    logic [31:0] r_align;
    logic [31:0] r_hdr;
    logic [63:0] r_fsz;
    logic [4:0]  r_nsect;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_align <= 32'd512;
            r_hdr   <= '0;
            r_fsz   <= '0;
            r_nsect <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ALIGN:  r_align <= i_cfg_data[31:0];
                CFG_HEADER: r_hdr   <= i_cfg_data[31:0];
                CFG_FILESZ: r_fsz   <= i_cfg_data;
                CFG_NSECT:  r_nsect <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // section table memory: one row per slot, registered read
    logic [255:0] r_mem [MaxSections];
    logic [255:0] r_rd;
    logic [IdxW-1:0] w_rd_addr;
    logic            w_wr_en;

    always_ff @(posedge i_clk) begin
        if (w_wr_en)
            r_mem[i_in.entry_index[IdxW-1:0]] <= {i_in.sect_virt_base,
                i_in.sect_virt_length, i_in.sect_raw_start, i_in.sect_raw_length};
        r_rd <= r_mem[w_rd_addr];
    end

    logic [63:0] w_vb, w_vl, w_rs, w_rl;
    assign {w_vb, w_vl, w_rs, w_rl} = r_rd;

    // working registers
    logic [63:0]     r_addr;
    logic [CntW-1:0] r_cnt;       // entries to scan
    logic [CntW-1:0] r_ptr;       // index of row now in r_rd
    logic            r_first;     // r_rd not yet valid this scan
    logic            r_virt;
    logic [IdxW-1:0] r_slot;
    logic [63:0]     r_delta, r_size, r_init, r_rl, r_aligned;
    logic            r_out_valid;
    t_rsp            r_out;
    logic            r_hold;      // finished result awaiting output slot
    t_rsp            r_pend;

    t_div_req w_div_req;
    t_div_rsp w_div_rsp;

    irfs_align_div u_div (
        .i_clk (i_clk),
        .i_rst_n (i_rst_n),
        .i_req (w_div_req),
        .o_rsp (w_div_rsp)
    );

    logic w_in_acc, w_out_acc;
    assign o_in_stall = (r_state != S_IDLE) || r_hold;
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_acc  = r_out_valid && !i_out_stall;
    assign w_wr_en    = w_in_acc && (i_in.req_type == REQ_LOAD) &&
                        ({1'b0, i_in.entry_index} < 5'(MaxSections));

    // scan compare on the row just read
    logic [63:0] w_d;
    logic        w_ge, w_vhit, w_rhit, w_last;
    assign w_d    = r_addr - w_vb;
    assign w_ge   = r_addr >= w_vb;
    assign w_vhit = w_ge && (w_d < w_vl);
    assign w_rhit = w_ge && (w_d < w_rl);
    assign w_last = (r_ptr + CntW'(1)) >= r_cnt;

    // final arithmetic; initialized byte count registered in S_CALC
    logic [63:0] w_init, w_room, w_rem, w_sl;
    always_comb begin
        w_init = '0;
        if (r_aligned < r_fsz)
            w_init = (r_rl < (r_fsz - r_aligned)) ? r_rl : (r_fsz - r_aligned);
        w_room = ~r_addr;
        w_rem  = ((r_size - r_delta) < w_room) ? (r_size - r_delta) : w_room;
        w_sl   = (w_rem < (r_init - r_delta)) ? w_rem : (r_init - r_delta);
    end

    // result staged for output
    t_rsp w_res;
    logic w_res_v;
    logic [63:0] w_hend;

    always_comb begin
        n_state   = r_state;
        w_res     = '0;
        w_res_v   = 1'b0;
        w_rd_addr = r_ptr[IdxW-1:0];
        w_div_req = '0;
        w_hend    = ({32'd0, r_hdr} < r_fsz) ? {32'd0, r_hdr} : r_fsz;
        unique case (r_state)
            S_IDLE: begin
                w_rd_addr = '0;
                if (w_in_acc && i_in.req_type == REQ_RESOLVE) n_state = S_FETCH;
            end
            S_FETCH: begin
                // decide header / fail / scan
                w_rd_addr = '0;
                if (r_align == 32'd0) begin
                    w_res_v = 1'b1; n_state = S_IDLE;
                end else if (r_addr < {32'd0, r_hdr}) begin
                    w_res_v = 1'b1; n_state = S_IDLE;
                    if (r_addr < w_hend) begin
                        w_res.span_found    = 1'b1;
                        w_res.span_length   = w_hend - r_addr;
                        w_res.file_position = r_addr;
                    end
                end else if (r_cnt == '0) begin
                    w_res_v = 1'b1; n_state = S_IDLE;
                end else begin
                    n_state = S_SCANV;
                end
            end
            S_SCANV, S_SCANR: begin
                // keep row r_ptr on the first cycle, then run one row ahead
                w_rd_addr = r_first ? r_ptr[IdxW-1:0] : IdxW'(r_ptr + CntW'(1));
                if (!r_first) begin
                    if ((r_state == S_SCANV) ? w_vhit : w_rhit) begin
                        n_state = S_DIV;
                        w_div_req.start    = 1'b1;
                        w_div_req.dividend = w_rs;
                        w_div_req.divisor  = r_align;
                    end else if (w_last) begin
                        if (r_state == S_SCANV) begin
                            n_state = S_SCANR;
                            w_rd_addr = '0;
                        end else begin
                            w_res_v = 1'b1; n_state = S_IDLE;
                        end
                    end
                end
            end
            S_DIV: begin
                if (w_div_rsp.done) n_state = S_CALC;
            end
            S_CALC: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                w_res_v = 1'b1; n_state = S_IDLE;
                if (w_rem != '0) begin
                    if (r_delta < r_init) begin
                        w_res.span_found    = 1'b1;
                        w_res.span_length   = w_sl;
                        w_res.file_position = r_aligned + r_delta;
                        w_res.region_number = 5'({1'b0, r_slot} + 5'd1);
                    end else if (r_virt) begin
                        w_res.span_found    = 1'b1;
                        w_res.backing_kind  = 1'b1;
                        w_res.span_length   = w_rem;
                        w_res.region_number = 5'({1'b0, r_slot} + 5'd1);
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_first <= 1'b1;
            r_ptr   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_FETCH || (r_state == S_SCANV && n_state == S_SCANR)) begin
                r_ptr   <= '0;
                r_first <= 1'b1;
            end else if (r_state == S_SCANV || r_state == S_SCANR) begin
                if (r_first) r_first <= 1'b0;
                else         r_ptr   <= r_ptr + CntW'(1);
            end
        end
    end

    // payload capture
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_addr <= i_in.query_address;
            r_cnt  <= (r_nsect > 5'(MaxSections)) ? CntW'(MaxSections) : CntW'(r_nsect);
        end
        if ((r_state == S_SCANV || r_state == S_SCANR) && !r_first) begin
            r_virt  <= (r_state == S_SCANV);
            r_slot  <= r_ptr[IdxW-1:0];
            r_delta <= w_d;
            r_size  <= (r_state == S_SCANV) ? w_vl : w_rl;
            r_rl    <= w_rl;
        end
        if (w_div_rsp.done) r_aligned <= w_div_rsp.rounded;
        if (r_state == S_CALC) r_init <= w_init;
    end

    // output register with one holding slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_hold      <= 1'b0;
        end else begin
            if (r_hold && (!r_out_valid || w_out_acc)) begin
                r_out_valid <= 1'b1;
                r_out       <= r_pend;
                r_hold      <= 1'b0;
            end else if (w_res_v && (!r_out_valid || w_out_acc)) begin
                r_out_valid <= 1'b1;
                r_out       <= w_res;
            end else if (w_out_acc) begin
                r_out_valid <= 1'b0;
            end
            if (w_res_v && !(!r_out_valid || w_out_acc)) begin
                r_hold <= 1'b1;
                r_pend <= w_res;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `ASSERT_CLK(a_no_accept_busy, i_clk, i_rst_n,
        (r_state != S_IDLE) |-> !w_in_acc, "input taken while busy")
    `ASSERT_CLK(a_div_done_in_div, i_clk, i_rst_n,
        w_div_rsp.done |-> (r_state == S_DIV), "divider done outside divide")
    `ASSERT_CLK(a_hold_needs_out, i_clk, i_rst_n,
        r_hold |-> r_out_valid, "pending result without output")
    `ASSERT_CLK(a_region_range, i_clk, i_rst_n,
        o_out_valid |-> (o_out.region_number <= 5'(MaxSections)), "region out of range")

endmodule
